/* src/assert_macros.svh */
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SDP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked also during reset
`define SDP_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/sdp_pkg.sv */
// types, constants and helper functions of the pdu to text decoder
package sdp_pkg;

    localparam int MaxChars = 10;

    localparam logic [7:0] PfxByte    = 8'h11;
    localparam logic [7:0] TypeIntl   = 8'h91;
    localparam logic [7:0] TypeAlpha  = 8'hD0;
    localparam logic [7:0] ChAt       = 8'h40;
    localparam logic [7:0] ChDollar   = 8'h24;
    localparam logic [7:0] ChQuest    = 8'h3F;
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChPlus     = 8'h2B;
    localparam logic [7:0] ChDash     = 8'h2D;
    localparam logic [7:0] ChColon    = 8'h3A;
    localparam logic [7:0] ChSlash    = 8'h2F;
    localparam logic [7:0] ChZero     = 8'h30;
    localparam logic [7:0] ChCr       = 8'h0D;
    localparam logic [7:0] ChLf       = 8'h0A;
    localparam logic [15:0] CyrLo     = 16'h0410;
    localparam logic [15:0] CyrHi     = 16'h0450;
    localparam logic [15:0] CyrOffset = 16'h0350;
    localparam logic [7:0] IeConcat8  = 8'h00;
    localparam logic [7:0] IeConcat16 = 8'h08;
    localparam logic [7:0] IeNone     = 8'hFF;

    localparam logic [1:0] AlphGsm   = 2'd0;
    localparam logic [1:0] AlphOctet = 2'd1;
    localparam logic [1:0] AlphUcs2  = 2'd2;
    localparam logic [1:0] AlphRsvd  = 2'd3;

    // reciprocal of seven, exact for every 12-bit operand
    localparam logic [11:0] RecipSeven = 12'd2341;

    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [3:0]               cnt;
        logic                     fin;
        logic                     rej;
    } cmd_t;

    typedef struct packed {
        logic [1:0] k;
        logic [6:0] s0;
        logic [6:0] s1;
        logic [7:0] buf_bits;
        logic [3:0] nbits;
        logic [7:0] left;
    } unp_t;

    function automatic cmd_t push(input cmd_t c, input logic [7:0] ch);
        cmd_t r;
        r = c;
        r.chars[c.cnt] = ch;
        r.cnt = c.cnt + 4'd1;
        return r;
    endfunction

    function automatic cmd_t push_dec(input cmd_t c, input logic [7:0] v);
        cmd_t r;
        logic [7:0] hund;
        logic [7:0] rem;
        logic [15:0] prod;
        logic [7:0] tens;
        logic [7:0] ones;
        r = c;
        if (v >= 8'd200) begin
            hund = 8'd2;
            rem = v - 8'd200;
        end else if (v >= 8'd100) begin
            hund = 8'd1;
            rem = v - 8'd100;
        end else begin
            hund = 8'd0;
            rem = v;
        end
        prod = 16'(rem) * 16'd205;
        tens = {3'b0, prod[15:11]};
        ones = rem - 8'(tens * 8'd10);
        if (v >= 8'd100) r = push(r, ChZero + hund);
        if (v >= 8'd10) r = push(r, ChZero + tens);
        r = push(r, ChZero + ones);
        return r;
    endfunction

    function automatic logic [7:0] div7(input logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'(RecipSeven);
        return (p[23:14] > 10'd255) ? 8'd255 : p[21:14];
    endfunction

    function automatic logic [7:0] gsm_fix(input logic [6:0] s);
        if (s == 7'd0) return ChAt;
        if (s == 7'd2) return ChDollar;
        return {1'b0, s};
    endfunction

    function automatic logic [7:0] body_fix(input logic [15:0] v);
        if (v == 16'd0) return ChQuest;
        if (v == 16'(ChLf) || v == 16'(ChCr)) return ChSpace;
        return v[7:0];
    endfunction

    function automatic unp_t unpack(input logic [7:0] bbuf, input logic [3:0] nb,
                                    input logic [7:0] b, input logic [7:0] left);
        unp_t r;
        logic [2:0] sh;
        logic [15:0] acc;
        logic [3:0] n;
        sh = nb[2:0];
        acc = {8'b0, bbuf} | ({8'b0, b} << sh);
        n = {1'b0, sh} + 4'd8;
        r.k = 2'd0;
        r.s0 = 7'd0;
        r.s1 = 7'd0;
        r.left = left;
        if (n >= 4'd7 && r.left != 8'd0) begin
            r.s0 = acc[6:0];
            acc = acc >> 7;
            n = n - 4'd7;
            r.left = r.left - 8'd1;
            r.k = 2'd1;
            if (n >= 4'd7 && r.left != 8'd0) begin
                r.s1 = acc[6:0];
                acc = acc >> 7;
                n = n - 4'd7;
                r.left = r.left - 8'd1;
                r.k = 2'd2;
            end
        end
        if (r.left == 8'd0) begin
            r.buf_bits = 8'd0;
            r.nbits = 4'd0;
        end else begin
            r.buf_bits = acc[7:0];
            r.nbits = n;
        end
        return r;
    endfunction

endpackage

/* src/sdp_front.sv */
// pdu parser: one octet a beat while the queue has room; turns each octet into a text batch, queued only when not empty
module sdp_front import sdp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  logic       q_full,
    output logic       in_ready,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_PFX1   = 5'd1;
    localparam logic [4:0] PH_PFX2   = 5'd2;
    localparam logic [4:0] PH_SKIP   = 5'd3;
    localparam logic [4:0] PH_SCLEN  = 5'd4;
    localparam logic [4:0] PH_SCA    = 5'd5;
    localparam logic [4:0] PH_FO     = 5'd6;
    localparam logic [4:0] PH_ALEN   = 5'd7;
    localparam logic [4:0] PH_ATYPE  = 5'd8;
    localparam logic [4:0] PH_ADIG   = 5'd9;
    localparam logic [4:0] PH_AALPHA = 5'd10;
    localparam logic [4:0] PH_PID    = 5'd11;
    localparam logic [4:0] PH_DCS    = 5'd12;
    localparam logic [4:0] PH_TS     = 5'd13;
    localparam logic [4:0] PH_TZ     = 5'd14;
    localparam logic [4:0] PH_UDL    = 5'd15;
    localparam logic [4:0] PH_UD     = 5'd16;
    localparam logic [4:0] PH_DONE   = 5'd17;

    logic [4:0] phase_reg, phase_next;
    logic [7:0] fc_reg, fc_next;
    logic [7:0] ad_reg, ad_next;
    logic [7:0] bb_reg, bb_next;
    logic [3:0] bl_reg, bl_next;
    logic [1:0] alph_reg, alph_next;
    logic       hp_reg, hp_next;
    logic [7:0] hs_reg, hs_next;
    logic [7:0] cr_reg, cr_next;
    logic [7:0] ie_reg, ie_next;
    logic [7:0] pt_reg, pt_next;
    logic [7:0] uh_reg, uh_next;

    logic accept;
    cmd_t cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (cmd.cnt != 4'd0);
    assign q_cmd    = cmd;

    always_comb begin
        logic [7:0] b;
        logic [7:0] idx;
        logic [7:0] sep;
        logic [7:0] n8;
        logic [15:0] v;
        logic [3:0] nb;
        logic hdr;
        logic seven;
        logic fin_now;
        logic [MaxChars-1:0][7:0] body;
        unp_t u;

        b = in_byte;
        idx = 8'd0;
        sep = 8'd0;
        n8 = 8'd0;
        v = 16'd0;
        nb = 4'd0;
        fin_now = 1'b0;
        body = '0;
        u = '0;
        cmd = '0;
        if (in_start) begin
            phase_next = PH_PFX1;
            fc_next = 8'd0; ad_next = 8'd0; bb_next = 8'd0; bl_next = 4'd0;
            alph_next = 2'd0; hp_next = 1'b0; hs_next = 8'd0; cr_next = 8'd0;
            ie_next = 8'd0; pt_next = 8'd0; uh_next = 8'd0;
        end else begin
            phase_next = phase_reg;
            fc_next = fc_reg; ad_next = ad_reg; bb_next = bb_reg; bl_next = bl_reg;
            alph_next = alph_reg; hp_next = hp_reg; hs_next = hs_reg; cr_next = cr_reg;
            ie_next = ie_reg; pt_next = pt_reg; uh_next = uh_reg;
        end
        hdr = hp_next;
        seven = (alph_next == AlphGsm) || (alph_next == AlphRsvd);

        unique case (phase_next)
            PH_PFX1: begin
                if (b != PfxByte) begin
                    cmd = push(cmd, 8'd0);
                    cmd.rej = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_PFX2;
                end
            end
            PH_PFX2: begin
                if (b != PfxByte) begin
                    cmd = push(cmd, 8'd0);
                    cmd.rej = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: phase_next = PH_SCLEN;
            PH_SCLEN: begin
                fc_next = b;
                phase_next = (b == 8'd0) ? PH_FO : PH_SCA;
            end
            PH_SCA: begin
                fc_next = fc_next - 8'd1;
                if (fc_next == 8'd0) phase_next = PH_FO;
            end
            PH_FO: begin
                if (b[1:0] != 2'b00) begin
                    cmd = push(cmd, 8'd0);
                    cmd.rej = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    hp_next = b[6];
                    phase_next = PH_ALEN;
                end
            end
            PH_ALEN: begin
                ad_next = b;
                phase_next = PH_ATYPE;
            end
            PH_ATYPE: begin
                if (b == TypeIntl) cmd = push(cmd, ChPlus);
                if (ad_next == 8'd0) begin
                    cmd = push(cmd, ChSpace);
                    phase_next = PH_PID;
                end else if (b == TypeAlpha) begin
                    fc_next = 8'(({1'b0, ad_next} + 9'd1) >> 1);
                    ad_next = div7({2'b0, ad_next, 2'b0});
                    bb_next = 8'd0;
                    bl_next = 4'd0;
                    phase_next = PH_AALPHA;
                end else begin
                    phase_next = PH_ADIG;
                end
            end
            PH_ADIG: begin
                if (ad_next != 8'd0) begin
                    cmd = push(cmd, {4'b0, b[3:0]} + ChZero);
                    ad_next = ad_next - 8'd1;
                end
                if (ad_next != 8'd0) begin
                    cmd = push(cmd, {4'b0, b[7:4]} + ChZero);
                    ad_next = ad_next - 8'd1;
                end
                if (ad_next == 8'd0) begin
                    cmd = push(cmd, ChSpace);
                    phase_next = PH_PID;
                end
            end
            PH_AALPHA: begin
                u = unpack(bb_next, bl_next, b, ad_next);
                ad_next = u.left;
                bb_next = u.buf_bits;
                bl_next = u.nbits;
                if (u.k != 2'd0) cmd = push(cmd, gsm_fix(u.s0));
                if (u.k == 2'd2) cmd = push(cmd, gsm_fix(u.s1));
                fc_next = fc_next - 8'd1;
                if (fc_next == 8'd0) begin
                    bb_next = 8'd0;
                    bl_next = 4'd0;
                    cmd = push(cmd, ChSpace);
                    phase_next = PH_PID;
                end
            end
            PH_PID: phase_next = PH_DCS;
            PH_DCS: begin
                alph_next = b[3:2];
                fc_next = 8'd6;
                phase_next = PH_TS;
            end
            PH_TS: begin
                if (fc_next == 8'd6 || fc_next == 8'd5) sep = ChDash;
                else if (fc_next == 8'd3 || fc_next == 8'd2) sep = ChColon;
                else sep = ChSpace;
                cmd = push(cmd, {4'b0, b[3:0]} + ChZero);
                cmd = push(cmd, {4'b0, b[7:4]} + ChZero);
                cmd = push(cmd, sep);
                fc_next = fc_next - 8'd1;
                if (fc_next == 8'd0) phase_next = PH_TZ;
            end
            PH_TZ: phase_next = PH_UDL;
            PH_UDL: begin
                hs_next = 8'd0;
                fc_next = 8'd0;
                bb_next = 8'd0;
                bl_next = 4'd0;
                ie_next = IeNone;
                pt_next = 8'd0;
                if (b == 8'd0) begin
                    fin_now = 1'b1;
                end else begin
                    cr_next = b;
                    phase_next = PH_UD;
                    if (!hdr && alph_next == AlphUcs2) begin
                        cr_next = {1'b0, b[7:1]};
                        if (cr_next == 8'd0) fin_now = 1'b1;
                    end
                end
            end
            PH_UD: begin
                idx = fc_next;
                if (fc_next != 8'd255) fc_next = fc_next + 8'd1;
                if (hdr && idx == 8'd0) begin
                    if (seven) begin
                        hs_next = div7(12'(({4'b0, b} + 12'd1) << 3) + 12'd6);
                    end else begin
                        n8 = (cr_next > b) ? (cr_next - b - 8'd1) : 8'd0;
                        hs_next = (b < cr_next) ? b : (cr_next - 8'd1);
                        if (alph_next == AlphUcs2) n8 = n8 >> 1;
                        cr_next = n8;
                    end
                end
                if (hdr && idx == 8'd1) ie_next = b;
                if (hdr && ((ie_next == IeConcat8 && idx == 8'd4) ||
                            (ie_next == IeConcat16 && idx == 8'd5)))
                    pt_next = b;
                if (seven) begin
                    u = unpack(bb_next, bl_next, b, cr_next);
                    cr_next = u.left;
                    bb_next = u.buf_bits;
                    bl_next = u.nbits;
                    if (u.k != 2'd0) begin
                        if (hs_next != 8'd0) begin
                            hs_next = hs_next - 8'd1;
                        end else begin
                            body[nb] = body_fix({8'b0, gsm_fix(u.s0)});
                            nb = nb + 4'd1;
                        end
                    end
                    if (u.k == 2'd2) begin
                        if (hs_next != 8'd0) begin
                            hs_next = hs_next - 8'd1;
                        end else begin
                            body[nb] = body_fix({8'b0, gsm_fix(u.s1)});
                            nb = nb + 4'd1;
                        end
                    end
                    fin_now = (cr_next == 8'd0);
                end else begin
                    if (!(hdr && idx == 8'd0)) begin
                        if (hs_next != 8'd0) begin
                            hs_next = hs_next - 8'd1;
                        end else if (cr_next != 8'd0) begin
                            if (alph_next == AlphOctet) begin
                                body[nb] = body_fix({8'b0, b});
                                nb = nb + 4'd1;
                                cr_next = cr_next - 8'd1;
                            end else if (bl_next == 4'd0) begin
                                uh_next = b;
                                bl_next = 4'd1;
                            end else begin
                                v = {uh_next, b};
                                bl_next = 4'd0;
                                if (v >= CyrLo && v < CyrHi) v = v - CyrOffset;
                                body[nb] = body_fix(v);
                                nb = nb + 4'd1;
                                cr_next = cr_next - 8'd1;
                            end
                        end
                    end
                    fin_now = (hs_next == 8'd0) && (cr_next == 8'd0);
                end
                if (hdr && nb == 4'd0 &&
                    ((ie_next == IeConcat8 && idx == 8'd5) ||
                     (ie_next == IeConcat16 && idx == 8'd6))) begin
                    cmd = push_dec(cmd, b);
                    cmd = push(cmd, ChSlash);
                    cmd = push_dec(cmd, pt_next);
                    cmd = push(cmd, ChSpace);
                end
                if (nb != 4'd0) cmd = push(cmd, body[0]);
                if (nb == 4'd2) cmd = push(cmd, body[1]);
                if (nb != 4'd0) ie_next = IeNone;
            end
            default: ;
        endcase

        if (fin_now) begin
            cmd = push(cmd, ChCr);
            cmd = push(cmd, ChLf);
            cmd.fin = 1'b1;
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fc_reg <= 8'd0; ad_reg <= 8'd0; bb_reg <= 8'd0; bl_reg <= 4'd0;
            alph_reg <= 2'd0; hp_reg <= 1'b0; hs_reg <= 8'd0; cr_reg <= 8'd0;
            ie_reg <= 8'd0; pt_reg <= 8'd0; uh_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            fc_reg <= fc_next; ad_reg <= ad_next; bb_reg <= bb_next; bl_reg <= bl_next;
            alph_reg <= alph_next; hp_reg <= hp_next; hs_reg <= hs_next; cr_reg <= cr_next;
            ie_reg <= ie_next; pt_reg <= pt_next; uh_reg <= uh_next;
        end
    end

endmodule

/* src/sdp_queue.sv */
// two-entry queue of text batches between parser and serialiser
module sdp_queue import sdp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_en,
    input  cmd_t push_cmd,
    input  logic pop_en,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push_en && !full;
    assign do_pop     = pop_en && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/sdp_back.sv */
// serialiser: sends one text byte a beat, while the receiver is ready, from the batch it has popped off the queue head
module sdp_back import sdp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

`include "assert_macros.svh"

    cmd_t       cur_reg;
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic       at_end, done_beat;

    assign at_end    = (idx_reg == cur_reg.cnt - 4'd1);
    assign done_beat = busy_reg && m_tready && at_end;
    assign pop       = head_valid && (!busy_reg || done_beat);

    assign m_tvalid = busy_reg;
    assign m_tdata  = cur_reg.chars[idx_reg];
    assign m_tlast  = at_end && (cur_reg.fin || cur_reg.rej);
    assign m_tuser  = at_end && cur_reg.rej;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
        end else if (done_beat) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_tready) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    `SDP_ASSERT(a_rej_is_last, m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0, "reject beat malformed")
    `SDP_ASSERT(a_idx_in_batch, busy_reg |-> idx_reg < cur_reg.cnt, "index beyond batch")
    `SDP_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

/* src/sms_deliver_pdu_to_text.sv */
// sms-deliver pdu to text decoder, top level
// an octet's batch is registered in the queue, then in the serialiser, before its first text beat (output idle, ready)
// throughput: one octet a cycle while the queue has room; the serialiser sends one text
// byte a cycle while the receiver is ready; an octet produces up to 10 text bytes
// a two-batch queue lets the parser run ahead of the serialiser, input stalls when it is full
// reset: synchronous, active low; parser returns to idle, queue and output empty
module sms_deliver_pdu_to_text import sdp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // pdu_byte
    input  logic       s_tuser,   // pdu_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // text_char
    output logic       m_tlast,
    output logic       m_tuser    // rejected
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_in, q_head;

    sdp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_start (s_tuser),
        .q_full   (q_full),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    sdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (q_push),
        .push_cmd   (q_in),
        .pop_en     (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    sdp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

/* dv/sms_deliver_pdu_to_text_tb.sv */
// self-checking testbench of the sms-deliver pdu to text decoder
module sms_deliver_pdu_to_text_tb import sdp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        P_IDLE, P_PFX1, P_PFX2, P_SKIP, P_SCLEN, P_SCA, P_FO, P_ALEN, P_ATYPE,
        P_ADIG, P_AALPHA, P_PID, P_DCS, P_TS, P_TZ, P_UDL, P_UD, P_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       rej;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       start;
        logic       has_ref;
        logic [7:0] ref_ch;
        logic       ref_last;
        logic       ref_rej;
    } stim_row_t;

    localparam int LimitCycles = 400000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    sms_deliver_pdu_to_text u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // decoder state
    phase_t     ph;
    logic [7:0] fcnt, adig, bbuf, sacc, hskip, left, ie_id, ptotal, uhigh;
    logic [3:0] nbits;
    logic [1:0] alph;
    logic       hdr;

    text_beat_t pending_text[$];
    text_beat_t step_out[$];
    int         n_fail;
    int         n_out;
    longint     cycles;
    bit         step_rows_typed;
    text_beat_t typed_beat;

    function automatic void clear_state();
        ph = P_IDLE; fcnt = 0; adig = 0; bbuf = 0; sacc = 0; hskip = 0;
        left = 0; ie_id = 0; ptotal = 0; uhigh = 0; nbits = 0; alph = 0; hdr = 0;
    endfunction

    function automatic void put(logic [7:0] c, logic l, logic r);
        text_beat_t t;
        t.ch = c; t.last = l; t.rej = r;
        if (step_out.size() < MaxChars) step_out.push_back(t);
    endfunction

    function automatic void put_dec(logic [7:0] v);
        if (v >= 100) put(8'(ChZero + v / 100), 0, 0);
        if (v >= 10) put(8'(ChZero + (v / 10) % 10), 0, 0);
        put(8'(ChZero + v % 10), 0, 0);
    endfunction

    function automatic void end_line();
        put(ChCr, 0, 0);
        put(ChLf, 1, 0);
        ph = P_DONE;
    endfunction

    function automatic logic [7:0] septet_char(logic [6:0] s);
        if (s == 0) return ChAt;
        if (s == 2) return ChDollar;
        return {1'b0, s};
    endfunction

    function automatic logic [7:0] text_char_of(logic [15:0] v);
        if (v == 0) return ChQuest;
        if (v == 16'h0A || v == 16'h0D) return ChSpace;
        return v[7:0];
    endfunction

    // shifts an octet into the septet buffer against the given count
    function automatic int shift_septets(logic [7:0] b, ref logic [7:0] cnt,
                                         ref logic [6:0] s[2]);
        logic [15:0] acc;
        int n, k;
        acc = {8'b0, bbuf} | ({8'b0, b} << nbits[2:0]);
        n = nbits[2:0] + 8;
        k = 0;
        while (n >= 7 && cnt != 0 && k < 2) begin
            s[k] = acc[6:0];
            k++;
            acc = acc >> 7;
            n -= 7;
            cnt--;
        end
        if (cnt == 0) begin
            bbuf = 0; nbits = 0;
        end else begin
            bbuf = acc[7:0]; nbits = 4'(n);
        end
        if (k > 0) sacc = {1'b0, s[k-1]};
        return k;
    endfunction

    function automatic void decode_user_octet(logic [7:0] b);
        logic [7:0] idx;
        logic [7:0] body[2];
        logic [6:0] s[2];
        logic [15:0] v;
        int nb, k, w;
        bit fin, seven;
        idx = fcnt;
        nb = 0;
        seven = (alph == AlphGsm || alph == AlphRsvd);
        if (fcnt < 255) fcnt++;
        if (hdr && idx == 0) begin
            if (seven) begin
                w = ((b + 1) * 8 + 6) / 7;
                hskip = (w > 255) ? 8'd255 : 8'(w);
            end else begin
                w = (left > b) ? (left - b - 1) : 0;
                hskip = (b < left) ? b : 8'(left - 1);
                if (alph == AlphUcs2) w = w >> 1;
                left = 8'(w);
            end
        end
        if (hdr && idx == 1) ie_id = b;
        if (hdr && ((ie_id == IeConcat8 && idx == 4) || (ie_id == IeConcat16 && idx == 5)))
            ptotal = b;
        if (seven) begin
            k = shift_septets(b, left, s);
            for (int j = 0; j < k; j++) begin
                if (hskip != 0) hskip--;
                else body[nb++] = text_char_of({8'b0, septet_char(s[j])});
            end
            fin = (left == 0);
        end else begin
            if (!(hdr && idx == 0)) begin
                if (hskip != 0) begin
                    hskip--;
                end else if (left != 0) begin
                    if (alph == AlphOctet) begin
                        body[nb++] = text_char_of({8'b0, b});
                        left--;
                    end else if (nbits == 0) begin
                        uhigh = b;
                        nbits = 1;
                    end else begin
                        v = {uhigh, b};
                        nbits = 0;
                        if (v >= CyrLo && v < CyrHi) v = v - CyrOffset;
                        body[nb++] = text_char_of(v);
                        left--;
                    end
                end
            end
            fin = (hskip == 0 && left == 0);
        end
        if (hdr && nb == 0 &&
            ((ie_id == IeConcat8 && idx == 5) || (ie_id == IeConcat16 && idx == 6))) begin
            put_dec(b);
            put(ChSlash, 0, 0);
            put_dec(ptotal);
            put(ChSpace, 0, 0);
        end
        for (int j = 0; j < nb; j++) put(body[j], 0, 0);
        if (nb > 0) ie_id = IeNone;
        if (fin) end_line();
    endfunction

    function automatic void decode_octet(logic [7:0] b, logic start);
        logic [6:0] s[2];
        logic [7:0] sep;
        int k;
        step_out.delete();
        if (start) begin
            clear_state();
            ph = P_PFX1;
        end
        case (ph)
            P_PFX1: if (b != PfxByte) begin put(0, 1, 1); ph = P_DONE; end else ph = P_PFX2;
            P_PFX2: if (b != PfxByte) begin put(0, 1, 1); ph = P_DONE; end else ph = P_SKIP;
            P_SKIP: ph = P_SCLEN;
            P_SCLEN: begin
                fcnt = b;
                ph = (b == 0) ? P_FO : P_SCA;
            end
            P_SCA: begin
                fcnt--;
                if (fcnt == 0) ph = P_FO;
            end
            P_FO: begin
                if (b[1:0] != 0) begin
                    put(0, 1, 1);
                    ph = P_DONE;
                end else begin
                    hdr = b[6];
                    ph = P_ALEN;
                end
            end
            P_ALEN: begin
                adig = b;
                ph = P_ATYPE;
            end
            P_ATYPE: begin
                if (b == TypeIntl) put(ChPlus, 0, 0);
                if (adig == 0) begin
                    put(ChSpace, 0, 0);
                    ph = P_PID;
                end else if (b == TypeAlpha) begin
                    fcnt = 8'((adig + 1) / 2);
                    adig = 8'((adig * 4) / 7);
                    bbuf = 0; nbits = 0;
                    ph = P_AALPHA;
                end else begin
                    ph = P_ADIG;
                end
            end
            P_ADIG: begin
                if (adig != 0) begin put({4'b0, b[3:0]} + ChZero, 0, 0); adig--; end
                if (adig != 0) begin put({4'b0, b[7:4]} + ChZero, 0, 0); adig--; end
                if (adig == 0) begin put(ChSpace, 0, 0); ph = P_PID; end
            end
            P_AALPHA: begin
                k = shift_septets(b, adig, s);
                for (int j = 0; j < k; j++) put(septet_char(s[j]), 0, 0);
                fcnt--;
                if (fcnt == 0) begin
                    bbuf = 0; nbits = 0;
                    put(ChSpace, 0, 0);
                    ph = P_PID;
                end
            end
            P_PID: ph = P_DCS;
            P_DCS: begin
                alph = b[3:2];
                fcnt = 6;
                ph = P_TS;
            end
            P_TS: begin
                sep = (fcnt == 6 || fcnt == 5) ? ChDash :
                      ((fcnt == 3 || fcnt == 2) ? ChColon : ChSpace);
                put({4'b0, b[3:0]} + ChZero, 0, 0);
                put({4'b0, b[7:4]} + ChZero, 0, 0);
                put(sep, 0, 0);
                fcnt--;
                if (fcnt == 0) ph = P_TZ;
            end
            P_TZ: ph = P_UDL;
            P_UDL: begin
                hskip = 0; fcnt = 0; bbuf = 0; nbits = 0; ie_id = IeNone; ptotal = 0;
                if (b == 0) begin
                    end_line();
                end else begin
                    left = b;
                    ph = P_UD;
                    if (!hdr && alph == AlphUcs2) begin
                        left = b >> 1;
                        if (left == 0) end_line();
                    end
                end
            end
            P_UD: decode_user_octet(b);
            default: ;
        endcase
    endfunction

    // directed rows: rejects, then the start of a pdu with an empty international sender and a short 8-bit body
    stim_row_t dir_rows[] = '{
        '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
        '{8'h11, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1},
        '{8'h11, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h11, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h03, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1},
        '{8'h11, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h11, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h91, 1'b0, 1'b1, ChPlus, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h21, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    logic [7:0] pdu_octets[$];
    logic       pdu_starts[$];

    function automatic void add_octet(logic [7:0] b, logic st);
        pdu_octets.push_back(b);
        pdu_starts.push_back(st);
    endfunction

    // mostly well-formed pdu with random content, some with a bad prefix or first octet
    function automatic void add_pdu();
        int sc, alen, atype, fo, dcs, udl, r;
        bit h;
        r = $urandom_range(0, 9);
        add_octet(8'h11, 1'b1);
        add_octet(r == 0 ? 8'($urandom) : 8'h11, 1'b0);
        add_octet(8'($urandom), 1'b0);
        sc = $urandom_range(0, 3);
        add_octet(8'(sc), 1'b0);
        for (int i = 0; i < sc; i++) add_octet(8'($urandom), 1'b0);
        h = $urandom_range(0, 2) == 0;
        fo = ($urandom & 8'hBC) | (h ? 8'h40 : 8'h00);
        if (r == 1) fo |= $urandom_range(1, 3);
        add_octet(8'(fo), 1'b0);
        alen = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 12);
        case ($urandom_range(0, 2))
            0: atype = TypeIntl;
            1: atype = TypeAlpha;
            default: atype = $urandom;
        endcase
        add_octet(8'(alen), 1'b0);
        add_octet(8'(atype), 1'b0);
        for (int i = 0; i < (alen + 1) / 2; i++) add_octet(8'($urandom), 1'b0);
        add_octet(8'($urandom), 1'b0);
        dcs = $urandom;
        add_octet(8'(dcs), 1'b0);
        for (int i = 0; i < 7; i++) add_octet(8'($urandom), 1'b0);
        udl = $urandom_range(0, 8) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 14);
        add_octet(8'(udl), 1'b0);
        for (int i = 0; i < (udl < 20 ? udl + 1 : 20); i++) begin
            if (h && i == 0) add_octet(8'($urandom_range(0, 8)), 1'b0);
            else if (h && i == 1) add_octet($urandom_range(0, 1) ? IeConcat8 : IeConcat16, 1'b0);
            else if ($urandom_range(0, 5) == 0) add_octet($urandom_range(0, 1) ? 8'h04 : 8'h00, 1'b0);
            else add_octet(8'($urandom), 1'b0);
        end
    endfunction

    task automatic send_octet(logic [7:0] b, logic st);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        decode_octet(b, st);
        foreach (step_out[i]) pending_text.push_back(step_out[i]);
    endtask

    // receiver with random stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge aclk) begin
        text_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_out++;
            if (pending_text.size() == 0) begin
                $error("text beat with nothing expected: %h", m_tdata);
                n_fail++;
            end else begin
                want = pending_text.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("text_char: expected %h, got %h", want.ch, m_tdata);
                    n_fail++;
                end
                if (m_tlast !== want.last) begin
                    $error("text_last: expected %b, got %b", want.last, m_tlast);
                    n_fail++;
                end
                if (m_tuser !== want.rej) begin
                    $error("rejected: expected %b, got %b", want.rej, m_tuser);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LimitCycles) begin
            $display("sms_deliver_pdu_to_text regression: fail");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        n_fail = 0;
        n_out = 0;
        cycles = 0;
        clear_state();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_octet(dir_rows[i].octet, dir_rows[i].start);
            if (dir_rows[i].has_ref) begin
                typed_beat.ch = dir_rows[i].ref_ch;
                typed_beat.last = dir_rows[i].ref_last;
                typed_beat.rej = dir_rows[i].ref_rej;
                if (step_out.size() == 0 || step_out[0] !== typed_beat) begin
                    $error("directed row %0d: predictor disagrees with table", i);
                    n_fail++;
                end
            end
        end
        // rest of the timestamp, time zone and a udl of three
        send_octet(8'h10, 1'b0);
        send_octet(8'h32, 1'b0);
        send_octet(8'h54, 1'b0);
        send_octet(8'h76, 1'b0);
        send_octet(8'h00, 1'b0);
        send_octet(8'h03, 1'b0);
        // directed body: 'A', zero, LF, then the end of line
        send_octet(8'h41, 1'b0);
        send_octet(8'h00, 1'b0);
        send_octet(8'h0A, 1'b0);

        // hold off until the line has drained
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_text.size() != 0);

        while (pdu_octets.size() < 260) add_pdu();
        while (pdu_octets.size() != 0) begin
            send_octet(pdu_octets.pop_front(), pdu_starts.pop_front());
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_text.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (100) @(posedge aclk);
        if (n_fail == 0 && pending_text.size() == 0) begin
            $display("sms_deliver_pdu_to_text regression: pass");
        end else begin
            $display("sms_deliver_pdu_to_text regression: fail");
        end
        $finish;
    end

endmodule

/* sms_deliver_pdu_to_text.f */
+incdir+src
src/sdp_pkg.sv
src/sdp_front.sv
src/sdp_queue.sv
src/sdp_back.sv
src/sms_deliver_pdu_to_text.sv
dv/sms_deliver_pdu_to_text_tb.sv
